// ===== hw/rtl/lps_pkg.sv =====
// Shared types, constants and saturating helpers for the LU pivot linear solver.
// No dependencies; every other file of the solver imports this package.
package lps_pkg;

	localparam int DATA_W        = 32;
	localparam int IDX_W         = 4;
	localparam int CMD_W         = 2;
	localparam int SIZE_W        = 5;
	localparam int N_MAX_DEF     = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_W-1:0] element_value;
	} lps_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         solution_index;
		logic signed [DATA_W-1:0] solution_value;
		logic                     singular;
		logic                     overflow;
		logic                     last;
	} lps_result_t;

	// Saturated value with its overflow mark
	typedef struct packed {
		logic                     ovf;
		logic signed [DATA_W-1:0] val;
	} lps_sat_t;

	// Divider completion, one-cycle strobe
	typedef struct packed {
		logic                     done;
		logic                     ovf;
		logic signed [DATA_W-1:0] q;
	} lps_div_res_t;

	function automatic lps_sat_t fx_sat64(input logic signed [63:0] v);
		lps_sat_t r;
		r.ovf = 1'b0;
		r.val = v[DATA_W-1:0];
		if (v > 64'(SAT_MAX)) begin
			r.ovf = 1'b1;
			r.val = SAT_MAX;
		end else if (v < 64'(SAT_MIN)) begin
			r.ovf = 1'b1;
			r.val = SAT_MIN;
		end
		return r;
	endfunction

	function automatic lps_sat_t fx_sub_sat(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		return fx_sat64(64'(a) - 64'(b));
	endfunction

	function automatic logic [DATA_W-1:0] fx_mag(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

// ===== hw/rtl/lps_div.sv =====
// Bit-serial fixed-point divider: (a * 2^FRAC_BITS) / d, rounded to nearest,
// ties away from zero, saturated to 32 bits. Depends on lps_pkg.
module lps_div #(
	parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [lps_pkg::DATA_W-1:0] a,
	input  logic signed [lps_pkg::DATA_W-1:0] d,
	output lps_pkg::lps_div_res_t            res
);
	import lps_pkg::*;

	localparam int W  = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(W + 1);

	logic              run_q, fin_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [W-1:0]      quo_q;
	logic [DATA_W-1:0] rem_q, ud_q;
	lps_div_res_t      res_q;

	logic [DATA_W:0]   rem2;
	logic              ge;
	logic [DATA_W-1:0] ua, ud;
	logic [W-1:0]      q_lim;

	assign ua    = fx_mag(a);
	assign ud    = fx_mag(d);
	assign rem2  = {rem_q, quo_q[W-1]};
	assign ge    = rem2 >= {1'b0, ud_q};
	assign q_lim = W'({1'b1, {(DATA_W-1){1'b0}}});
	assign res   = res_q;

	// Load operands, shift one quotient bit a cycle, then saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			ud_q  <= '0;
			res_q <= '0;
		end else begin
			res_q.done <= 1'b0;
			if (start) begin
				if (d == '0) begin
					res_q.done <= 1'b1;
					res_q.ovf  <= 1'b1;
					res_q.q    <= a[DATA_W-1] ? SAT_MIN : SAT_MAX;
				end else begin
					neg_q <= a[DATA_W-1] ^ d[DATA_W-1];
					ud_q  <= ud;
					rem_q <= '0;
					quo_q <= (W'(ua) << FRAC_BITS) + W'(ud >> 1);
					cnt_q <= CW'(W);
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				rem_q <= ge ? DATA_W'(rem2 - {1'b0, ud_q}) : DATA_W'(rem2);
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q      <= 1'b0;
				res_q.done <= 1'b1;
				if (!neg_q && quo_q >= q_lim) begin
					res_q.ovf <= 1'b1;
					res_q.q   <= SAT_MAX;
				end else if (neg_q && quo_q > q_lim) begin
					res_q.ovf <= 1'b1;
					res_q.q   <= SAT_MIN;
				end else begin
					res_q.ovf <= 1'b0;
					res_q.q   <= neg_q ? -DATA_W'(quo_q) : DATA_W'(quo_q);
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q && !fin_q)
		else $error("divider started while busy");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> res_q.done)
		else $error("divider finished without strobe");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && cnt_q == CW'(1) |=> fin_q && !run_q)
		else $error("divider count did not end the run");

endmodule

// ===== hw/rtl/lu_pivot_linear_solver_unit.sv =====
// Top level of the LU pivot linear solver: command port, sequencer and the
// matrix and vector memories. Depends on lps_pkg and lps_div.
//
// Load commands (matrix or right-hand element) are accepted back to back
// while idle. A solve command holds busy high while the sequencer factors
// the matrix in place (partial pivoting, physical row swaps), runs forward
// and backward substitution and emits x[0]..x[n-1], each on the result port
// for exactly one cycle with result_valid high; the receiver cannot stall
// it. All matrix work goes through the single read port of the matrix
// memory, and the bit-serial divider is used once per multiplier and once
// per diagonal. A zero pivot stops factorisation at once and gives n zero
// results with singular set.
module lu_pivot_linear_solver_unit #(
	parameter int N_MAX     = lps_pkg::N_MAX_DEF,
	parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lps_pkg::lps_item_t          item,
	input  logic                        cfg_we,
	input  logic [lps_pkg::SIZE_W-1:0]  cfg_wdata,
	output logic                        result_valid,
	output lps_pkg::lps_result_t        result
);
	import lps_pkg::*;

	localparam int IW    = $clog2(N_MAX);
	localparam int DEPTH = N_MAX * N_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int N_LIM = (N_MAX < 16) ? N_MAX : 16;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_PIV_RD  = 5'd1;
	localparam logic [4:0] S_PIV_CMP = 5'd2;
	localparam logic [4:0] S_SW_RA   = 5'd3;
	localparam logic [4:0] S_SW_RB   = 5'd4;
	localparam logic [4:0] S_SW_WA   = 5'd5;
	localparam logic [4:0] S_SW_WB   = 5'd6;
	localparam logic [4:0] S_SWV_RA  = 5'd7;
	localparam logic [4:0] S_SWV_RB  = 5'd8;
	localparam logic [4:0] S_SWV_WA  = 5'd9;
	localparam logic [4:0] S_SWV_WB  = 5'd10;
	localparam logic [4:0] S_EL_RD   = 5'd11;
	localparam logic [4:0] S_EL_DIV  = 5'd12;
	localparam logic [4:0] S_EL_WAIT = 5'd13;
	localparam logic [4:0] S_MS_RD   = 5'd14;
	localparam logic [4:0] S_MS_MUL  = 5'd15;
	localparam logic [4:0] S_MS_RND  = 5'd16;
	localparam logic [4:0] S_MS_SUB  = 5'd17;
	localparam logic [4:0] S_FW_RD   = 5'd18;
	localparam logic [4:0] S_FW_ACC  = 5'd19;
	localparam logic [4:0] S_FW_TRD  = 5'd20;
	localparam logic [4:0] S_FW_MUL  = 5'd21;
	localparam logic [4:0] S_FW_RND  = 5'd22;
	localparam logic [4:0] S_FW_SUB  = 5'd23;
	localparam logic [4:0] S_FW_WR   = 5'd24;
	localparam logic [4:0] S_BK_RD   = 5'd25;
	localparam logic [4:0] S_BK_ACC  = 5'd26;
	localparam logic [4:0] S_BK_TRD  = 5'd27;
	localparam logic [4:0] S_BK_MUL  = 5'd28;
	localparam logic [4:0] S_BK_RND  = 5'd29;
	localparam logic [4:0] S_BK_SUB  = 5'd30;
	localparam logic [4:0] S_BK_DRD  = 5'd31;

	// Back substitution division and output use a second group of state codes
	// with the top bit set, declared further down; X_NONE is the idle state
	localparam logic [5:0] X_NONE    = 6'd0;

	logic [5:0] st_q;

	function automatic logic [AW-1:0] faddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(32'(r) * N_MAX + 32'(c));
	endfunction

	// Memories
	logic signed [DATA_W-1:0] fmem [DEPTH];
	logic signed [DATA_W-1:0] vmem [N_MAX];
	logic signed [DATA_W-1:0] f_rd_q, v_rd_q;
	logic                     f_re, f_we, v_re, v_we;
	logic [AW-1:0]            f_ra, f_wa;
	logic [IW-1:0]            v_ra, v_wa;
	logic signed [DATA_W-1:0] f_wd, v_wd;

	// Sequencer registers
	logic [SIZE_W-1:0]        size_q;
	logic [IW-1:0]            nm1_q, k_q, i_q, j_q, p_q;
	logic signed [DATA_W-1:0] piv_q, ta_q, acc_q, l_q, m_q;
	logic signed [63:0]       prod_s1;
	logic                     sing_q, ovf_q, valid_q;
	lps_result_t              result_q;

	logic                     div_start;
	logic signed [DATA_W-1:0] div_a, div_d;
	lps_div_res_t             div_res;
	lps_sat_t                 rnd, sub;
	logic                     accept, row_ok, col_ok;
	logic                     pick;
	logic signed [DATA_W-1:0] best_piv;
	logic [IW-1:0]            best_p;
	int                       n_sel;

	localparam logic [5:0] T_BK_DIV  = 6'd32;
	localparam logic [5:0] T_BK_WAIT = 6'd33;
	localparam logic [5:0] T_OUT_RD  = 6'd34;
	localparam logic [5:0] T_OUT_EM  = 6'd35;

	assign busy         = st_q != {1'b0, S_IDLE};
	assign accept       = start && !busy;
	assign row_ok       = 32'(item.row_index) < N_MAX;
	assign col_ok       = 32'(item.col_index) < N_MAX;
	assign result_valid = valid_q;
	assign result       = result_q;

	// Round the registered product and saturate; subtract from the running value
	always_comb begin
		rnd = fx_sat64((prod_s1 + HALF) >>> FRAC_BITS);
		sub = fx_sub_sat((st_q == {1'b0, S_MS_SUB}) ? f_rd_q : acc_q, m_q);
	end

	// Pivot candidate: first row holding the largest magnitude
	always_comb begin
		pick     = (i_q == k_q) || (fx_mag(f_rd_q) > fx_mag(piv_q));
		best_piv = pick ? f_rd_q : piv_q;
		best_p   = pick ? i_q : p_q;
	end

	// Clamp the configured order
	always_comb begin
		if (size_q == '0)
			n_sel = 1;
		else if (32'(size_q) > N_LIM)
			n_sel = N_LIM;
		else
			n_sel = 32'(size_q);
	end

	// Memory port and divider control per sequencer step
	always_comb begin
		f_re = 1'b0; f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
		v_re = 1'b0; v_ra = '0; v_we = 1'b0; v_wa = '0; v_wd = '0;
		div_start = 1'b0; div_a = '0; div_d = '0;
		unique case (st_q) inside
			{1'b0, S_IDLE}: begin
				if (accept && item.cmd == CMD_LOAD_A && row_ok && col_ok) begin
					f_we = 1'b1;
					f_wa = AW'(32'(item.row_index) * N_MAX + 32'(item.col_index));
					f_wd = item.element_value;
				end
				if (accept && item.cmd == CMD_LOAD_B && row_ok) begin
					v_we = 1'b1;
					v_wa = IW'(item.row_index);
					v_wd = item.element_value;
				end
			end
			{1'b0, S_PIV_RD}: begin f_re = 1'b1; f_ra = faddr(i_q, k_q); end
			{1'b0, S_SW_RA}:  begin f_re = 1'b1; f_ra = faddr(k_q, j_q); end
			{1'b0, S_SW_RB}:  begin f_re = 1'b1; f_ra = faddr(p_q, j_q); end
			{1'b0, S_SW_WA}:  begin f_we = 1'b1; f_wa = faddr(k_q, j_q); f_wd = f_rd_q; end
			{1'b0, S_SW_WB}:  begin f_we = 1'b1; f_wa = faddr(p_q, j_q); f_wd = ta_q; end
			{1'b0, S_SWV_RA}: begin v_re = 1'b1; v_ra = k_q; end
			{1'b0, S_SWV_RB}: begin v_re = 1'b1; v_ra = p_q; end
			{1'b0, S_SWV_WA}: begin v_we = 1'b1; v_wa = k_q; v_wd = v_rd_q; end
			{1'b0, S_SWV_WB}: begin v_we = 1'b1; v_wa = p_q; v_wd = ta_q; end
			{1'b0, S_EL_RD}:  begin f_re = 1'b1; f_ra = faddr(i_q, k_q); end
			{1'b0, S_EL_DIV}: begin div_start = 1'b1; div_a = f_rd_q; div_d = piv_q; end
			{1'b0, S_EL_WAIT}: begin
				if (div_res.done) begin
					f_we = 1'b1; f_wa = faddr(i_q, k_q); f_wd = div_res.q;
				end
			end
			{1'b0, S_MS_RD}:  begin f_re = 1'b1; f_ra = faddr(k_q, j_q); end
			{1'b0, S_MS_MUL}: begin f_re = 1'b1; f_ra = faddr(i_q, j_q); end
			{1'b0, S_MS_SUB}: begin f_we = 1'b1; f_wa = faddr(i_q, j_q); f_wd = sub.val; end
			{1'b0, S_FW_RD}, {1'b0, S_BK_RD}, T_OUT_RD: begin
				v_re = 1'b1; v_ra = i_q;
			end
			{1'b0, S_FW_TRD}, {1'b0, S_BK_TRD}: begin
				f_re = 1'b1; f_ra = faddr(i_q, j_q);
				v_re = 1'b1; v_ra = j_q;
			end
			{1'b0, S_FW_WR}:  begin v_we = 1'b1; v_wa = i_q; v_wd = acc_q; end
			{1'b0, S_BK_DRD}: begin f_re = 1'b1; f_ra = faddr(i_q, i_q); end
			T_BK_DIV: begin div_start = 1'b1; div_a = acc_q; div_d = f_rd_q; end
			T_BK_WAIT: begin
				if (div_res.done) begin
					v_we = 1'b1; v_wa = i_q; v_wd = div_res.q;
				end
			end
			default: ;
		endcase
	end

	// Matrix memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (f_we)
			fmem[f_wa] <= f_wd;
		if (f_re)
			f_rd_q <= fmem[f_ra];
	end

	// Vector memory
	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_wa] <= v_wd;
		if (v_re)
			v_rd_q <= vmem[v_ra];
	end

	lps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.d      (div_d),
		.res    (div_res)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= SIZE_W'(16);
		else if (cfg_we)
			size_q <= cfg_wdata;
	end

	// Sequencer: factorise, substitute forward and back, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= X_NONE;
			nm1_q    <= '0;
			k_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			p_q      <= '0;
			piv_q    <= '0;
			ta_q     <= '0;
			acc_q    <= '0;
			l_q      <= '0;
			m_q      <= '0;
			prod_s1  <= '0;
			sing_q   <= 1'b0;
			ovf_q    <= 1'b0;
			valid_q  <= 1'b0;
			result_q <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (st_q) inside
				{1'b0, S_IDLE}: begin
					if (accept && item.cmd == CMD_SOLVE) begin
						nm1_q  <= IW'(n_sel - 1);
						k_q    <= '0;
						i_q    <= '0;
						sing_q <= 1'b0;
						ovf_q  <= 1'b0;
						st_q   <= {1'b0, S_PIV_RD};
					end
				end
				{1'b0, S_PIV_RD}: st_q <= {1'b0, S_PIV_CMP};
				{1'b0, S_PIV_CMP}: begin
					piv_q <= best_piv;
					p_q   <= best_p;
					if (i_q == nm1_q) begin
						if (best_piv == '0) begin
							sing_q <= 1'b1;
							i_q    <= '0;
							st_q   <= T_OUT_RD;
						end else if (best_p != k_q) begin
							j_q  <= '0;
							st_q <= {1'b0, S_SW_RA};
						end else if (k_q == nm1_q) begin
							i_q  <= '0;
							st_q <= {1'b0, S_FW_RD};
						end else begin
							i_q  <= k_q + 1'b1;
							st_q <= {1'b0, S_EL_RD};
						end
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= {1'b0, S_PIV_RD};
					end
				end
				{1'b0, S_SW_RA}: st_q <= {1'b0, S_SW_RB};
				{1'b0, S_SW_RB}: begin
					ta_q <= f_rd_q;
					st_q <= {1'b0, S_SW_WA};
				end
				{1'b0, S_SW_WA}: st_q <= {1'b0, S_SW_WB};
				{1'b0, S_SW_WB}: begin
					if (j_q == nm1_q) begin
						st_q <= {1'b0, S_SWV_RA};
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= {1'b0, S_SW_RA};
					end
				end
				{1'b0, S_SWV_RA}: st_q <= {1'b0, S_SWV_RB};
				{1'b0, S_SWV_RB}: begin
					ta_q <= v_rd_q;
					st_q <= {1'b0, S_SWV_WA};
				end
				{1'b0, S_SWV_WA}: st_q <= {1'b0, S_SWV_WB};
				{1'b0, S_SWV_WB}: begin
					if (k_q == nm1_q) begin
						i_q  <= '0;
						st_q <= {1'b0, S_FW_RD};
					end else begin
						i_q  <= k_q + 1'b1;
						st_q <= {1'b0, S_EL_RD};
					end
				end
				{1'b0, S_EL_RD}:  st_q <= {1'b0, S_EL_DIV};
				{1'b0, S_EL_DIV}: st_q <= {1'b0, S_EL_WAIT};
				{1'b0, S_EL_WAIT}: begin
					if (div_res.done) begin
						l_q   <= div_res.q;
						ovf_q <= ovf_q | div_res.ovf;
						j_q   <= k_q + 1'b1;
						st_q  <= {1'b0, S_MS_RD};
					end
				end
				{1'b0, S_MS_RD}: st_q <= {1'b0, S_MS_MUL};
				{1'b0, S_MS_MUL}: begin
					prod_s1 <= 64'(l_q) * 64'(f_rd_q);
					st_q    <= {1'b0, S_MS_RND};
				end
				{1'b0, S_MS_RND}, {1'b0, S_FW_RND}, {1'b0, S_BK_RND}: begin
					m_q   <= rnd.val;
					ovf_q <= ovf_q | rnd.ovf;
					st_q  <= st_q + 1'b1;
				end
				{1'b0, S_MS_SUB}: begin
					ovf_q <= ovf_q | sub.ovf;
					if (j_q == nm1_q) begin
						if (i_q == nm1_q) begin
							k_q  <= k_q + 1'b1;
							i_q  <= k_q + 1'b1;
							st_q <= {1'b0, S_PIV_RD};
						end else begin
							i_q  <= i_q + 1'b1;
							st_q <= {1'b0, S_EL_RD};
						end
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= {1'b0, S_MS_RD};
					end
				end
				{1'b0, S_FW_RD}: st_q <= {1'b0, S_FW_ACC};
				{1'b0, S_FW_ACC}: begin
					acc_q <= v_rd_q;
					j_q   <= '0;
					st_q  <= (i_q == '0) ? {1'b0, S_FW_WR} : {1'b0, S_FW_TRD};
				end
				{1'b0, S_FW_TRD}, {1'b0, S_BK_TRD}: st_q <= st_q + 1'b1;
				{1'b0, S_FW_MUL}, {1'b0, S_BK_MUL}: begin
					prod_s1 <= 64'(f_rd_q) * 64'(v_rd_q);
					st_q    <= st_q + 1'b1;
				end
				{1'b0, S_FW_SUB}: begin
					acc_q <= sub.val;
					ovf_q <= ovf_q | sub.ovf;
					if (j_q + 1'b1 == i_q) begin
						st_q <= {1'b0, S_FW_WR};
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= {1'b0, S_FW_TRD};
					end
				end
				{1'b0, S_FW_WR}: begin
					if (i_q == nm1_q) begin
						st_q <= {1'b0, S_BK_RD};
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= {1'b0, S_FW_RD};
					end
				end
				{1'b0, S_BK_RD}: st_q <= {1'b0, S_BK_ACC};
				{1'b0, S_BK_ACC}: begin
					acc_q <= v_rd_q;
					j_q   <= i_q + 1'b1;
					st_q  <= (i_q == nm1_q) ? {1'b0, S_BK_DRD} : {1'b0, S_BK_TRD};
				end
				{1'b0, S_BK_SUB}: begin
					acc_q <= sub.val;
					ovf_q <= ovf_q | sub.ovf;
					if (j_q == nm1_q) begin
						st_q <= {1'b0, S_BK_DRD};
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= {1'b0, S_BK_TRD};
					end
				end
				{1'b0, S_BK_DRD}: st_q <= T_BK_DIV;
				T_BK_DIV: st_q <= T_BK_WAIT;
				T_BK_WAIT: begin
					if (div_res.done) begin
						ovf_q <= ovf_q | div_res.ovf;
						if (i_q == '0) begin
							st_q <= T_OUT_RD;
						end else begin
							i_q  <= i_q - 1'b1;
							st_q <= {1'b0, S_BK_RD};
						end
					end
				end
				T_OUT_RD: st_q <= T_OUT_EM;
				T_OUT_EM: begin
					valid_q                 <= 1'b1;
					result_q.solution_index <= IDX_W'(i_q);
					result_q.solution_value <= sing_q ? '0 : v_rd_q;
					result_q.singular       <= sing_q;
					result_q.overflow       <= ovf_q;
					result_q.last           <= i_q == nm1_q;
					if (i_q == nm1_q) begin
						st_q <= X_NONE;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= T_OUT_RD;
					end
				end
				default: st_q <= X_NONE;
			endcase
		end
	end

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("run still busy after last result");
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a solve in progress");
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> st_q == {1'b0, S_EL_WAIT} || st_q == T_BK_WAIT)
		else $error("divider result arrived while not awaited");
	a_no_mem_clash: assert property (@(posedge clk) disable iff (!arst_n)
		f_we && f_re |-> f_wa != f_ra)
		else $error("matrix read and write of one entry in one cycle");

endmodule
